/* src/adpe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package adpe_pkg;
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW = 1;

	localparam logic [4:0] GRP_DP_IMM_SHIFT = 5'd0;
	localparam logic [4:0] GRP_MISC1        = 5'd1;
	localparam logic [4:0] GRP_DP_REG_SHIFT = 5'd2;
	localparam logic [4:0] GRP_MISC2        = 5'd3;
	localparam logic [4:0] GRP_MUL_XLS      = 5'd4;
	localparam logic [4:0] GRP_DP_IMM       = 5'd5;
	localparam logic [4:0] GRP_UNDEF        = 5'd6;
	localparam logic [4:0] GRP_MSR_IMM      = 5'd7;
	localparam logic [4:0] GRP_LS_IMM       = 5'd8;
	localparam logic [4:0] GRP_LS_REG       = 5'd9;
	localparam logic [4:0] GRP_MEDIA        = 5'd10;
	localparam logic [4:0] GRP_ARCH_UNDEF   = 5'd11;
	localparam logic [4:0] GRP_LS_MULTI     = 5'd12;
	localparam logic [4:0] GRP_BRANCH       = 5'd13;
	localparam logic [4:0] GRP_CP_LS        = 5'd14;
	localparam logic [4:0] GRP_CP_DP        = 5'd15;
	localparam logic [4:0] GRP_CP_RT        = 5'd16;
	localparam logic [4:0] GRP_SWI          = 5'd17;
	localparam logic [4:0] GRP_UNCOND       = 5'd18;

	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_EOR = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_RSB = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_ADC = 4'd5;
	localparam logic [3:0] OP_SBC = 4'd6;
	localparam logic [3:0] OP_RSC = 4'd7;
	localparam logic [3:0] OP_TST = 4'd8;
	localparam logic [3:0] OP_TEQ = 4'd9;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_CMN = 4'd11;
	localparam logic [3:0] OP_ORR = 4'd12;
	localparam logic [3:0] OP_MOV = 4'd13;
	localparam logic [3:0] OP_BIC = 4'd14;
	localparam logic [3:0] OP_MVN = 4'd15;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	typedef struct packed {
		logic [31:0] word;
		logic [4:0]  grp;
		logic        is_dp;
	} dec_t;
endpackage
`default_nettype wire

/* src/adpe_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module adpe_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [31:0]       instr_word,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output adpe_pkg::dec_t         q_data
);
	import adpe_pkg::*;

	dec_t            mem_q [QDEPTH];
	logic [QAW-1:0]  wp_q, rp_q;
	logic [QAW:0]    cnt_q;
	dec_t            d;
	logic            push, pop;

	function automatic logic [4:0] group_of(input logic [31:0] w);
		logic b4, b7, b20;
		logic [1:0] b65, b2423, b2221;
		logic [4:0] g;
		b4 = w[4]; b7 = w[7]; b20 = w[20];
		b65 = w[6:5]; b2423 = w[24:23]; b2221 = w[22:21];
		g = GRP_CP_DP;
		if (w[31:28] == 4'hf) g = GRP_UNCOND;
		else case (w[27:25])
			3'd0: begin
				if (b7 && b4) g = GRP_MUL_XLS;
				else if (!b4) g = (!b20 && b2423 == 2'd2) ? GRP_MISC1 : GRP_DP_IMM_SHIFT;
				else g = (!b20 && b2423 == 2'd2 && !b7) ? GRP_MISC2 : GRP_DP_REG_SHIFT;
			end
			3'd1: begin
				if (b2423 == 2'd2 && !b20) g = b2221[0] ? GRP_MSR_IMM : GRP_UNDEF;
				else g = GRP_DP_IMM;
			end
			3'd2: g = GRP_LS_IMM;
			3'd3: begin
				if (!b4) g = GRP_LS_REG;
				else if (b2423 == 2'd3 && b2221 == 2'd3 && b20 && b7 && b65 == 2'd3)
					g = GRP_ARCH_UNDEF;
				else g = GRP_MEDIA;
			end
			3'd4: g = GRP_LS_MULTI;
			3'd5: g = GRP_BRANCH;
			3'd6: g = GRP_CP_LS;
			default: begin
				if (b2423[1]) g = GRP_SWI;
				else g = b4 ? GRP_CP_RT : GRP_CP_DP;
			end
		endcase
		return g;
	endfunction

	always_comb begin
		d.word  = instr_word;
		d.grp   = group_of(instr_word);
		d.is_dp = (d.grp == GRP_DP_IMM_SHIFT) || (d.grp == GRP_DP_REG_SHIFT)
			|| (d.grp == GRP_DP_IMM);
	end

	assign in_ready = (cnt_q != QDEPTH[QAW:0]);
	assign q_valid  = (cnt_q != '0);
	assign q_data   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
		end
	end
endmodule
`default_nettype wire

/* src/adpe_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module adpe_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  wire adpe_pkg::dec_t    q_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [4:0]             group_code,
	output logic                   cond_passed,
	output logic                   reg_written,
	output logic [3:0]             dest_index,
	output logic [31:0]            alu_value,
	output logic [3:0]             flags_after
);
	import adpe_pkg::*;

	logic [31:0] rf_q [16];
	logic [3:0]  nzcv_q;
	logic        vld_q;

	logic [31:0] w, a, m, rs, op2, res, x, y, rot_imm;
	logic [3:0]  opc, rd, f_new;
	logic [1:0]  typ;
	logic [7:0]  amt;
	logic [4:0]  rot;
	logic        n, z, c, v, pass, sc, cin, cc, vv, exec, wr, logical, borrow;
	logic [32:0] wide;

	function automatic logic [31:0] rdr(input logic [31:0] r15, input logic [31:0] rv,
		input logic [3:0] i);
		return (i == 4'd15) ? r15 + 32'd8 : rv;
	endfunction

	always_comb begin
		w = q_data.word;
		n = nzcv_q[3]; z = nzcv_q[2]; cin = nzcv_q[1]; v = nzcv_q[0];
		case (w[31:28])
			4'd0: pass = z;
			4'd1: pass = !z;
			4'd2: pass = cin;
			4'd3: pass = !cin;
			4'd4: pass = n;
			4'd5: pass = !n;
			4'd6: pass = v;
			4'd7: pass = !v;
			4'd8: pass = cin && !z;
			4'd9: pass = !cin || z;
			4'd10: pass = (n == v);
			4'd11: pass = (n != v);
			4'd12: pass = !z && (n == v);
			4'd13: pass = z || (n != v);
			default: pass = 1'b1;
		endcase
		opc = w[24:21];
		rd  = w[15:12];
		typ = w[6:5];
		a   = rdr(rf_q[15], rf_q[w[19:16]], w[19:16]);
		m   = rdr(rf_q[15], rf_q[w[3:0]], w[3:0]);
		rs  = rf_q[w[11:8]];
		rot = {w[11:8], 1'b0};
		rot_imm = ({24'd0, w[7:0]} >> rot) | ({24'd0, w[7:0]} << (6'd32 - {1'b0, rot}));
		sc  = cin;
		op2 = m;
		amt = '0;
		if (q_data.grp == GRP_DP_IMM) begin
			op2 = rot_imm;
			sc  = (rot != 5'd0) ? rot_imm[31] : cin;
		end else begin
			if (q_data.grp == GRP_DP_REG_SHIFT) amt = rs[7:0];
			else begin
				amt = {3'd0, w[11:7]};
				if (amt == 8'd0 && (typ == SH_LSR || typ == SH_ASR)) amt = 8'd32;
			end
			if (q_data.grp == GRP_DP_IMM_SHIFT && w[11:7] == 5'd0 && typ == SH_ROR) begin
				sc  = m[0];
				op2 = {cin, m[31:1]};
			end else if (amt != 8'd0) begin
				case (typ)
					SH_LSL: begin
						if (amt < 8'd32) begin
							op2 = m << amt[4:0];
							sc  = m[5'd0 - amt[4:0]];
						end else begin
							op2 = '0;
							sc  = (amt == 8'd32) ? m[0] : 1'b0;
						end
					end
					SH_LSR: begin
						if (amt < 8'd32) begin
							op2 = m >> amt[4:0];
							sc  = m[amt[4:0] - 5'd1];
						end else begin
							op2 = '0;
							sc  = (amt == 8'd32) ? m[31] : 1'b0;
						end
					end
					SH_ASR: begin
						if (amt < 8'd32) begin
							op2 = $unsigned($signed(m) >>> amt[4:0]);
							sc  = m[amt[4:0] - 5'd1];
						end else begin
							op2 = {32{m[31]}};
							sc  = m[31];
						end
					end
					default: begin
						if (amt[4:0] == 5'd0) begin
							sc = m[31];
						end else begin
							op2 = (m >> amt[4:0]) | (m << (6'd32 - {1'b0, amt[4:0]}));
							sc  = m[amt[4:0] - 5'd1];
						end
					end
				endcase
			end
		end
		// arithmetic: subtract forms share one adder as x + ~y + carry
		x = (opc == OP_RSB || opc == OP_RSC) ? op2 : a;
		y = (opc == OP_RSB || opc == OP_RSC) ? a : op2;
		borrow = (opc == OP_SBC || opc == OP_RSC) ? !cin : 1'b0;
		cc = cin; vv = v; res = '0; wide = '0;
		case (opc)
			OP_AND, OP_TST: res = a & op2;
			OP_EOR, OP_TEQ: res = a ^ op2;
			OP_ORR: res = a | op2;
			OP_MOV: res = op2;
			OP_BIC: res = a & ~op2;
			OP_MVN: res = ~op2;
			OP_SUB, OP_CMP, OP_SBC, OP_RSB, OP_RSC: begin
				wide = {1'b0, x} + {1'b0, ~y} + {32'd0, !borrow};
				res  = wide[31:0];
				cc   = wide[32];
				vv   = (x[31] ^ y[31]) & (x[31] ^ res[31]);
			end
			default: begin
				wide = {1'b0, a} + {1'b0, op2} + {32'd0, (opc == OP_ADC) && cin};
				res  = wide[31:0];
				cc   = wide[32];
				vv   = (a[31] ^ res[31]) & (op2[31] ^ res[31]);
			end
		endcase
		logical = (opc == OP_AND) || (opc == OP_EOR) || (opc == OP_TST) || (opc == OP_TEQ)
			|| (opc >= OP_ORR);
		if (logical) begin
			cc = sc; vv = v;
		end
		exec = pass && q_data.is_dp;
		wr   = exec && !(opc == OP_TST || opc == OP_TEQ || opc == OP_CMP || opc == OP_CMN);
		f_new = nzcv_q;
		if (exec && w[20] && rd != 4'd15) f_new = {res[31], res == 32'd0, cc, vv};
	end

	assign out_valid = vld_q;
	assign q_ready   = !vld_q || out_ready;

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			group_code  <= q_data.grp;
			cond_passed <= pass;
			reg_written <= wr;
			dest_index  <= rd;
			alu_value   <= exec ? res : 32'd0;
			flags_after <= f_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			nzcv_q <= '0;
			for (int i = 0; i < 16; i++) rf_q[i] <= '0;
		end else begin
			if (q_valid && q_ready) begin
				vld_q  <= 1'b1;
				nzcv_q <= f_new;
				if (wr) rf_q[rd] <= res;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

/* src/arm_data_processing_execute.sv */
`timescale 1ns / 1ps
`default_nettype none
// ARM data-processing execute: one instruction word per request in, one result per
// request out, sustaining one request per cycle while the output is not stalled. The
// front classifies each word into its group and pushes it into a two-entry queue; the
// back tests the condition, runs the barrel shifter and ALU against the register file
// and NZCV flags and registers the result, so dependent instructions follow back to
// back with no stall. A request is held first in the queue and then in the back's
// output registers, from which the result is presented; the flag and register update
// loop in the back sets the rate.
module arm_data_processing_execute (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] instr_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       group_code,
	output logic             cond_passed,
	output logic             reg_written,
	output logic [3:0]       dest_index,
	output logic [31:0]      alu_value,
	output logic [3:0]       flags_after
);
	import adpe_pkg::*;

	// decoded request between front and back
	dec_t q_data;
	logic q_valid, q_ready;

	adpe_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .instr_word,
		.q_valid, .q_ready, .q_data
	);

	adpe_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .group_code, .cond_passed, .reg_written,
		.dest_index, .alu_value, .flags_after
	);
endmodule
`default_nettype wire

/* src/adpe_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module adpe_sva (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        cond_passed,
	input wire logic        reg_written,
	input wire logic [4:0]  group_code,
	input wire logic [31:0] alu_value,
	input wire logic [3:0]  flags_after
);
	import adpe_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(alu_value) && $stable(flags_after))
		else $error("result dropped while stalled");
	a_wr_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> cond_passed)
		else $error("write without condition pass");
	a_grp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> (group_code == GRP_DP_IMM_SHIFT
			|| group_code == GRP_DP_REG_SHIFT || group_code == GRP_DP_IMM))
		else $error("write from non data-processing group");
	a_noexec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cond_passed |-> alu_value == 32'd0 && !reg_written)
		else $error("failed condition produced a value");
endmodule

bind arm_data_processing_execute adpe_sva u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .cond_passed, .reg_written,
	.group_code, .alu_value, .flags_after
);
`default_nettype wire
